### rtl/core/cpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_pkg: shared types and constants of the compacting pool allocator
// Field widths of the command and result words, result codes and the
// decoded command that travels from the front end to the engine.
// ----------------------------------------------------------------------------
package cpa_pkg;

  // fixed widths of the port fields
  localparam int HANDLE_W = 8;
  localparam int SIZE_W   = 13;
  localparam int OFFSET_W = 12;
  localparam int SOURCE_W = 13;
  localparam int LENGTH_W = 13;

  // defaults of the top level parameters
  localparam int DEF_POOL_BYTES = 4096;
  localparam int DEF_SLOTS      = 16;
  localparam int DEF_TAG_BITS   = 8;

  // depth of the command queue between front end and engine
  localparam int QUEUE_DEPTH = 2;

  // command codes on command_i
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_RELOC = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_NO_SLOT   = 3'd1,
    STATUS_POOL_FULL = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_ZERO_SIZE = 3'd4
  } status_e;

  // classified command
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_ZERO  = 2'd2
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [HANDLE_W-1:0] tag;
    logic [SIZE_W-1:0]   size;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    kind_e               kind;
    status_e             status;
    logic [HANDLE_W-1:0] chunk_tag;
    logic [OFFSET_W-1:0] offset;
    logic [SOURCE_W-1:0] source;
    logic [LENGTH_W-1:0] length;
    logic                last;
  } result_t;

endpackage

### rtl/core/cpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_front: command intake
// Takes a command word when the queue has room, masks the handle to the tag
// width and classifies the command for the engine.
// ----------------------------------------------------------------------------
module cpa_front #(
  parameter int TAG_BITS = cpa_pkg::DEF_TAG_BITS
) (
  input  logic                          start,
  output logic                          busy,
  input  logic                          command_i,
  input  logic [cpa_pkg::HANDLE_W-1:0]  handle_i,
  input  logic [cpa_pkg::SIZE_W-1:0]    size_i,
  input  cpa_pkg::q_stat_t              q_stat_i,
  output logic                          push_o,
  output cpa_pkg::cmd_t                 cmd_o
);
  import cpa_pkg::*;

  localparam int TW = (TAG_BITS < HANDLE_W) ? TAG_BITS : HANDLE_W;

  assign busy   = q_stat_i.full;
  assign push_o = start && !q_stat_i.full;

  always_comb begin
    cmd_o.tag  = HANDLE_W'(handle_i[TW-1:0]);
    cmd_o.size = size_i;
    if (command_i == CMD_FREE) begin
      cmd_o.op = OP_FREE;
    end else if (size_i == '0) begin
      cmd_o.op = OP_ZERO;
    end else begin
      cmd_o.op = OP_ALLOC;
    end
  end

endmodule

### rtl/core/cpa_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_queue: command queue
// Short first-in first-out buffer of classified commands.
// ----------------------------------------------------------------------------
module cpa_queue #(
  parameter int DEPTH = cpa_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cpa_pkg::cmd_t    data_i,
  input  logic             pop_i,
  output cpa_pkg::cmd_t    data_o,
  output cpa_pkg::q_stat_t stat_o
);
  import cpa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/core/cpa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_back: allocation engine
// Owns the slot table and the pool top, carries out one command at a time
// and drives one result word per cycle at most.
// ----------------------------------------------------------------------------
module cpa_back #(
  parameter int POOL_BYTES = cpa_pkg::DEF_POOL_BYTES,
  parameter int SLOTS      = cpa_pkg::DEF_SLOTS,
  parameter int TAG_BITS   = cpa_pkg::DEF_TAG_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cpa_pkg::q_stat_t q_stat_i,
  input  cpa_pkg::cmd_t    cmd_i,
  output logic             pop_o,
  output logic             res_valid_o,
  output cpa_pkg::result_t res_o
);
  import cpa_pkg::*;

  localparam int TW    = (TAG_BITS < HANDLE_W) ? TAG_BITS : HANDLE_W;
  localparam int TOP_W = $clog2(POOL_BYTES + 1);
  localparam int OFF_W = $clog2(POOL_BYTES);
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CW    = ((TOP_W > SIZE_W) ? TOP_W : SIZE_W) + 1;
  localparam int SW    = TOP_W + 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FIND  = 5'b00010,
    ST_MOVE  = 5'b00100,
    ST_RELOC = 5'b01000,
    ST_REPLY = 5'b10000
  } state_e;

  // slot table
  logic [TOP_W-1:0] slot_size_q   [SLOTS];
  logic [TW-1:0]    slot_tag_q    [SLOTS];
  logic [OFF_W-1:0] slot_offset_q [SLOTS];

  logic [TOP_W-1:0] top_q, top_d;
  logic [CNT_W-1:0] used_q, used_d;
  state_e           state_q, state_d;
  cmd_t             cur_q, cur_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic [OFF_W-1:0] hit_off_q, hit_off_d;
  logic [TOP_W-1:0] hit_sz_q, hit_sz_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  result_t          res_q, res_d;
  logic             res_valid_q, res_valid_d;

  // slot write ports
  logic             size_we, tag_we, off_we;
  logic [IDX_W-1:0] size_widx, tag_widx, off_widx;
  logic [TOP_W-1:0] size_wdata;
  logic [OFF_W-1:0] off_wdata;

  // parallel lookup
  logic             hit_any, empty_any;
  logic [IDX_W-1:0] match_idx, empty_idx;

  logic [CW-1:0]    room, req;
  logic             top_over;
  logic [SW-1:0]    src, len;
  logic [TOP_W-1:0] rd_off, new_off;

  always_comb begin
    hit_any   = 1'b0;
    empty_any = 1'b0;
    match_idx = '0;
    empty_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_size_q[i] != '0 && slot_tag_q[i] == cur_q.tag[TW-1:0]) begin
        hit_any   = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (slot_size_q[i] == '0) begin
        empty_any = 1'b1;
        empty_idx = IDX_W'(i);
      end
    end
  end

  assign top_over = CW'(top_q) > CW'(POOL_BYTES);
  assign room     = CW'(POOL_BYTES) - CW'(top_q);
  assign req      = CW'(cur_q.size);
  assign src      = SW'(hit_off_q) + SW'(hit_sz_q);
  assign len      = (SW'(top_q) > src) ? SW'(top_q) - src : '0;
  assign rd_off   = TOP_W'(slot_offset_q[idx_q]);
  assign new_off  = (rd_off >= hit_sz_q) ? rd_off - hit_sz_q : '0;

  always_comb begin
    top_d       = top_q;
    used_d      = used_q;
    state_d     = state_q;
    cur_d       = cur_q;
    hit_idx_d   = hit_idx_q;
    hit_off_d   = hit_off_q;
    hit_sz_d    = hit_sz_q;
    idx_d       = idx_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    pop_o       = 1'b0;
    size_we     = 1'b0;
    tag_we      = 1'b0;
    off_we      = 1'b0;
    size_widx   = empty_idx;
    tag_widx    = empty_idx;
    off_widx    = empty_idx;
    size_wdata  = TOP_W'(cur_q.size);
    off_wdata   = OFF_W'(top_q);

    // default word: final reply with error fields cleared
    res_d.kind      = KIND_REPLY;
    res_d.status    = STATUS_OK;
    res_d.chunk_tag = cur_q.tag;
    res_d.offset    = '0;
    res_d.source    = '0;
    res_d.length    = '0;
    res_d.last      = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          cur_d   = cmd_i;
          state_d = ST_FIND;
        end
      end
      ST_FIND: begin
        state_d = ST_IDLE;
        unique case (cur_q.op)
          OP_ZERO: begin
            res_valid_d  = 1'b1;
            res_d.status = STATUS_ZERO_SIZE;
          end
          OP_ALLOC: begin
            res_valid_d = 1'b1;
            priority if (used_q >= CNT_W'(SLOTS)) begin
              res_d.status = STATUS_NO_SLOT;
            end else if (top_over || req > room) begin
              res_d.status = STATUS_POOL_FULL;
            end else if (!empty_any) begin
              res_d.status = STATUS_NO_SLOT;
            end else begin
              size_we      = 1'b1;
              tag_we       = 1'b1;
              off_we       = 1'b1;
              top_d        = TOP_W'(CW'(top_q) + req);
              used_d       = used_q + 1'b1;
              res_d.offset = OFFSET_W'(top_q);
              res_d.length = cur_q.size;
            end
          end
          OP_FREE: begin
            if (!hit_any) begin
              res_valid_d  = 1'b1;
              res_d.status = STATUS_NOT_FOUND;
            end else begin
              hit_idx_d = match_idx;
              hit_off_d = slot_offset_q[match_idx];
              hit_sz_d  = slot_size_q[match_idx];
              state_d   = ST_MOVE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_MOVE: begin
        res_valid_d     = 1'b1;
        res_d.kind      = KIND_MOVE;
        res_d.chunk_tag = '0;
        res_d.offset    = OFFSET_W'(hit_off_q);
        res_d.source    = SOURCE_W'(src);
        res_d.length    = LENGTH_W'(len);
        res_d.last      = 1'b0;
        idx_d           = '0;
        state_d         = ST_RELOC;
      end
      ST_RELOC: begin
        if (idx_q != hit_idx_q && slot_size_q[idx_q] != '0 &&
            slot_offset_q[idx_q] > hit_off_q) begin
          off_we          = 1'b1;
          off_widx        = idx_q;
          off_wdata       = OFF_W'(new_off);
          res_valid_d     = 1'b1;
          res_d.kind      = KIND_RELOC;
          res_d.chunk_tag = HANDLE_W'(slot_tag_q[idx_q]);
          res_d.offset    = OFFSET_W'(new_off);
          res_d.last      = 1'b0;
        end
        if (idx_q == IDX_W'(SLOTS - 1)) begin
          state_d = ST_REPLY;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_REPLY: begin
        top_d        = (top_q >= hit_sz_q) ? top_q - hit_sz_q : '0;
        used_d       = (used_q != '0) ? used_q - 1'b1 : '0;
        size_we      = 1'b1;
        size_widx    = hit_idx_q;
        size_wdata   = '0;
        res_valid_d  = 1'b1;
        res_d.offset = OFFSET_W'(hit_off_q);
        res_d.length = LENGTH_W'(hit_sz_q);
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= '0;
      used_q      <= '0;
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_size_q[i] <= '0;
      end
    end else begin
      top_q       <= top_d;
      used_q      <= used_d;
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (size_we) begin
        slot_size_q[size_widx] <= size_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    hit_idx_q <= hit_idx_d;
    hit_off_q <= hit_off_d;
    hit_sz_q  <= hit_sz_d;
    idx_q     <= idx_d;
    res_q     <= res_d;
    if (tag_we) begin
      slot_tag_q[tag_widx] <= cur_q.tag[TW-1:0];
    end
    if (off_we) begin
      slot_offset_q[off_widx] <= off_wdata;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### rtl/core/compacting_pool_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_pool_allocator_top: compacting pool allocator
// Slot table of chunks over a byte pool; allocate bumps the top, free
// compacts the pool and reports the moves for a copy engine.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word (command_i, handle_i, size_i) is taken at a
//   rising edge with start high and busy low. busy rises only while the
//   two-entry command queue is full, so up to two commands can wait while
//   the engine works on a third.
//   Result channel: each result word sits on the result ports for one cycle
//   with result_valid_o high. The receiver cannot stall it; it must take
//   every word. last_o marks the final reply of each command.
//   Sequencing: a taken word is written into the command queue, and the
//   engine pops it from there. Allocate and every error reply go through
//   dequeue, table lookup in parallel over all slots, and reply. A good free
//   goes through dequeue, lookup, move descriptor, the relocation sweep
//   (the move descriptor sits on the ports in its first step), the reply
//   step and the step in which the reply sits on the ports. The engine
//   works on one command at a time and pops the next one only from idle;
//   the sweep reads one slot per cycle.
//   Reset: all slots empty, pool top zero, queue empty, no result pending.
//   The table is cleared at once; no clearing pass follows reset.
// ----------------------------------------------------------------------------
module compacting_pool_allocator_top #(
  parameter int POOL_BYTES = cpa_pkg::DEF_POOL_BYTES,
  parameter int SLOTS      = cpa_pkg::DEF_SLOTS,
  parameter int TAG_BITS   = cpa_pkg::DEF_TAG_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic                         command_i,
  input  logic [cpa_pkg::HANDLE_W-1:0] handle_i,
  input  logic [cpa_pkg::SIZE_W-1:0]   size_i,
  // result channel
  output logic                         result_valid_o,
  output logic [1:0]                   kind_o,
  output logic [2:0]                   status_o,
  output logic [cpa_pkg::HANDLE_W-1:0] chunk_tag_o,
  output logic [cpa_pkg::OFFSET_W-1:0] offset_o,
  output logic [cpa_pkg::SOURCE_W-1:0] source_o,
  output logic [cpa_pkg::LENGTH_W-1:0] length_o,
  output logic                         last_o
);
  import cpa_pkg::*;

  q_stat_t q_stat;
  cmd_t    push_cmd, head_cmd;
  logic    push, pop;
  result_t res;

  // classify and enqueue the incoming word
  cpa_front #(
    .TAG_BITS (TAG_BITS)
  ) u_front (
    .start     (start),
    .busy      (busy),
    .command_i (command_i),
    .handle_i  (handle_i),
    .size_i    (size_i),
    .q_stat_i  (q_stat),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  // decouple intake from the engine
  cpa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .pop_i  (pop),
    .data_o (head_cmd),
    .stat_o (q_stat)
  );

  // execute commands against the slot table
  cpa_back #(
    .POOL_BYTES (POOL_BYTES),
    .SLOTS      (SLOTS),
    .TAG_BITS   (TAG_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .res_valid_o (result_valid_o),
    .res_o       (res)
  );

  // unpack the registered result word
  assign kind_o      = res.kind;
  assign status_o    = res.status;
  assign chunk_tag_o = res.chunk_tag;
  assign offset_o    = res.offset;
  assign source_o    = res.source;
  assign length_o    = res.length;
  assign last_o      = res.last;

endmodule

### rtl/core/cpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_checker: port checks of the compacting pool allocator
// Watches the result channel for word sequencing and field rules.
// ----------------------------------------------------------------------------
module cpa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         result_valid_o,
  input logic [1:0]                   kind_o,
  input logic [2:0]                   status_o,
  input logic [cpa_pkg::SOURCE_W-1:0] source_o,
  input logic [cpa_pkg::LENGTH_W-1:0] length_o,
  input logic                         last_o
);
  import cpa_pkg::*;

  logic reply_w, move_w, reloc_w;
  assign reply_w = result_valid_o && kind_o == KIND_REPLY;
  assign move_w  = result_valid_o && kind_o == KIND_MOVE;
  assign reloc_w = result_valid_o && kind_o == KIND_RELOC;

  // only the final reply closes a command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (last_o == reply_w))
    else $error("last flag does not match a final reply");

  // descriptors carry no error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move_w || reloc_w) |-> (status_o == STATUS_OK))
    else $error("descriptor with error status");

  // relocation words leave source and length clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reloc_w |-> (source_o == '0 && length_o == '0))
    else $error("relocation word with move fields set");

  // a move descriptor is followed by the relocation sweep, never a reply
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    move_w |=> !reply_w)
    else $error("reply right after a move descriptor");

  // a final reply is not followed at once by a descriptor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_w |=> !(result_valid_o && kind_o != KIND_REPLY))
    else $error("descriptor right after a final reply");

endmodule

bind compacting_pool_allocator_top cpa_checker u_cpa_checker (.*);

### bench/tb_compacting_pool_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_compacting_pool_allocator_top: self-checking bench of the pool allocator
// Drives allocate and free words through the start/busy handshake, predicts
// every reply, move descriptor and relocation with a private slot table, and
// compares each result word field by field as it leaves the block.
// ----------------------------------------------------------------------------

// Slot table shadow plus the queue of result words still owed by the block.
class alloc_scoreboard;

  localparam int NSLOTS = cpa_pkg::DEF_SLOTS;
  localparam int POOL   = cpa_pkg::DEF_POOL_BYTES;

  int unsigned           chunk_len[NSLOTS];
  logic [7:0]            chunk_owner[NSLOTS];
  int unsigned           chunk_base[NSLOTS];
  int unsigned           top_mark;
  int unsigned           live_chunks;
  cpa_pkg::result_t      owed_q[$];
  int                    fails;

  function void owe(cpa_pkg::kind_e kind, cpa_pkg::status_e status, logic [7:0] tag,
                    int unsigned off, int unsigned src, int unsigned len, logic last);
    cpa_pkg::result_t r;
    r.kind      = kind;
    r.status    = status;
    r.chunk_tag = tag;
    r.offset    = off[cpa_pkg::OFFSET_W-1:0];
    r.source    = src[cpa_pkg::SOURCE_W-1:0];
    r.length    = len[cpa_pkg::LENGTH_W-1:0];
    r.last      = last;
    owed_q.push_back(r);
  endfunction

  // Update the shadow table for one accepted word and queue its results.
  function void note_command(logic cmd, logic [7:0] tag, logic [12:0] size);
    int hit;
    int unsigned off, len, src;
    hit = -1;
    if (cmd == cpa_pkg::CMD_ALLOC) begin
      if (size == 0) begin
        owe(cpa_pkg::KIND_REPLY, cpa_pkg::STATUS_ZERO_SIZE, tag, 0, 0, 0, 1'b1);
        return;
      end
      if (live_chunks >= NSLOTS) begin
        owe(cpa_pkg::KIND_REPLY, cpa_pkg::STATUS_NO_SLOT, tag, 0, 0, 0, 1'b1);
        return;
      end
      if (top_mark > POOL || POOL - top_mark < size) begin
        owe(cpa_pkg::KIND_REPLY, cpa_pkg::STATUS_POOL_FULL, tag, 0, 0, 0, 1'b1);
        return;
      end
      for (int i = 0; i < NSLOTS; i++) begin
        if (hit < 0 && chunk_len[i] == 0) hit = i;
      end
      if (hit < 0) begin
        owe(cpa_pkg::KIND_REPLY, cpa_pkg::STATUS_NO_SLOT, tag, 0, 0, 0, 1'b1);
        return;
      end
      chunk_len[hit]   = size;
      chunk_owner[hit] = tag;
      chunk_base[hit]  = top_mark;
      owe(cpa_pkg::KIND_REPLY, cpa_pkg::STATUS_OK, tag, top_mark, 0, size, 1'b1);
      top_mark += size;
      live_chunks++;
      return;
    end
    // free: first live slot with this tag wins; empty slots never match
    for (int i = 0; i < NSLOTS; i++) begin
      if (hit < 0 && chunk_len[i] != 0 && chunk_owner[i] == tag) hit = i;
    end
    if (hit < 0) begin
      owe(cpa_pkg::KIND_REPLY, cpa_pkg::STATUS_NOT_FOUND, tag, 0, 0, 0, 1'b1);
      return;
    end
    off = chunk_base[hit];
    len = chunk_len[hit];
    src = off + len;
    owe(cpa_pkg::KIND_MOVE, cpa_pkg::STATUS_OK, 8'd0, off, src,
        (top_mark > src) ? top_mark - src : 0, 1'b0);
    for (int i = 0; i < NSLOTS; i++) begin
      if (i != hit && chunk_len[i] != 0 && chunk_base[i] > off) begin
        chunk_base[i] = (chunk_base[i] >= len) ? chunk_base[i] - len : 0;
        owe(cpa_pkg::KIND_RELOC, cpa_pkg::STATUS_OK, chunk_owner[i], chunk_base[i],
            0, 0, 1'b0);
      end
    end
    top_mark = (top_mark >= len) ? top_mark - len : 0;
    if (live_chunks > 0) live_chunks--;
    chunk_len[hit]   = 0;
    chunk_owner[hit] = '0;
    chunk_base[hit]  = 0;
    owe(cpa_pkg::KIND_REPLY, cpa_pkg::STATUS_OK, tag, off, 0, len, 1'b1);
  endfunction

  function void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endfunction

  function void check_result(cpa_pkg::result_t got);
    cpa_pkg::result_t want;
    if (owed_q.size() == 0) begin
      $error("result word with nothing outstanding: kind %0d tag %0d",
             got.kind, got.chunk_tag);
      fails++;
      return;
    end
    want = owed_q.pop_front();
    check_field("kind", want.kind, got.kind);
    check_field("status", want.status, got.status);
    check_field("chunk_tag", want.chunk_tag, got.chunk_tag);
    check_field("offset", want.offset, got.offset);
    check_field("source", want.source, got.source);
    check_field("length", want.length, got.length);
    check_field("last", want.last, got.last);
  endfunction

  // Pick the tag of a random live chunk; returns 0 when the table is empty.
  function bit pick_live_tag(output logic [7:0] tag);
    logic [7:0] tags[$];
    tag = '0;
    for (int i = 0; i < NSLOTS; i++) begin
      if (chunk_len[i] != 0) tags.push_back(chunk_owner[i]);
    end
    if (tags.size() == 0) return 1'b0;
    tag = tags[$urandom_range(0, tags.size() - 1)];
    return 1'b1;
  endfunction

endclass

module tb_compacting_pool_allocator_top;

  import cpa_pkg::*;

  localparam int SLOTS      = DEF_SLOTS;
  localparam int POOL_BYTES = DEF_POOL_BYTES;
  localparam int RAND_WORDS = 480;
  // longest quiet stretch: a full free sweep per queued word plus sender gaps
  localparam int STALL_LIMIT = 2000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                command = CMD_ALLOC;
  logic [HANDLE_W-1:0] handle = '0;
  logic [SIZE_W-1:0]   size = '0;
  logic                result_valid;
  logic [1:0]          kind;
  logic [2:0]          status;
  logic [HANDLE_W-1:0] chunk_tag;
  logic [OFFSET_W-1:0] offset;
  logic [SOURCE_W-1:0] source;
  logic [LENGTH_W-1:0] length;
  logic                last;

  alloc_scoreboard ledger = new;
  bit              no_gaps = 1'b0;
  int              quiet_cycles = 0;

  compacting_pool_allocator_top #(
    .POOL_BYTES(POOL_BYTES),
    .SLOTS     (SLOTS),
    .TAG_BITS  (DEF_TAG_BITS)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start         (start),
    .busy          (busy),
    .command_i     (command),
    .handle_i      (handle),
    .size_i        (size),
    .result_valid_o(result_valid),
    .kind_o        (kind),
    .status_o      (status),
    .chunk_tag_o   (chunk_tag),
    .offset_o      (offset),
    .source_o      (source),
    .length_o      (length),
    .last_o        (last)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Take every result word at the edge that ends its cycle; the block
  // cannot be stalled, so there is nothing to drive on this side.
  always @(posedge clk) begin
    result_t got;
    if (rst_n && result_valid) begin
      got.kind      = kind_e'(kind);
      got.status    = status_e'(status);
      got.chunk_tag = chunk_tag;
      got.offset    = offset;
      got.source    = source;
      got.length    = length;
      got.last      = last;
      ledger.check_result(got);
    end
  end

  // Watchdog: count edges at which neither channel moves a word.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || result_valid) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one command word and hold it until the block takes it. Insert
  // random gaps first unless the no-gap stretch is running. Drive at the
  // rising edge so the next edge samples settled values.
  task automatic send_word(logic cmd, logic [7:0] tag, logic [12:0] bytes);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 35) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start   <= 1'b1;
    command <= cmd;
    handle  <= tag;
    size    <= bytes;
    do @(posedge clk); while (busy);
    ledger.note_command(cmd, tag, bytes);
  endtask

  // One random word: mostly well-formed allocate/free traffic over live
  // chunks, with zero sizes, unknown handles and oversize requests mixed in.
  task automatic send_random_word();
    logic [7:0]  tag;
    logic [12:0] bytes;
    int unsigned roll;
    bit          do_free;
    roll = $urandom_range(0, 99);
    if (ledger.live_chunks == 0) do_free = (roll < 8);
    else if (ledger.live_chunks >= SLOTS) do_free = (roll < 90);
    else do_free = (roll < 45);
    if (do_free) begin
      // free a live chunk most of the time, a stray handle otherwise
      if ($urandom_range(0, 99) < 15 || !ledger.pick_live_tag(tag))
        tag = 8'($urandom_range(0, 255));
      send_word(CMD_FREE, tag, 13'($urandom_range(0, POOL_BYTES)));
    end else begin
      // small handle set produces duplicates; the full range covers every bit
      tag = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7))
                                        : 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < 4) bytes = '0;
      else if (roll < 80) bytes = 13'($urandom_range(1, 255));
      else if (roll < 94) bytes = 13'($urandom_range(256, 1023));
      else if (roll < 98) bytes = 13'($urandom_range(1024, POOL_BYTES));
      else bytes = 13'(POOL_BYTES);
      send_word(CMD_ALLOC, tag, bytes);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero size, free on an empty table (tag zero must not match
    // an empty slot), a chunk filling the whole pool, pool full, free of
    // the top chunk with nothing above it.
    send_word(CMD_ALLOC, 8'h00, 13'd0);
    send_word(CMD_FREE, 8'h00, 13'd0);
    send_word(CMD_ALLOC, 8'hFF, 13'(POOL_BYTES));
    send_word(CMD_ALLOC, 8'h01, 13'd1);
    send_word(CMD_FREE, 8'hFF, 13'h1FFF);
    // Fill every slot, with one handle used twice.
    for (int i = 0; i < SLOTS; i++) begin
      send_word(CMD_ALLOC, (i == 3 || i == 9) ? 8'h5A : 8'(i * 17), 13'(i * 16 + 1));
    end
    // Table full, then free the lowest chunk so every other one relocates,
    // then release the duplicate handle twice (first slot goes first).
    send_word(CMD_ALLOC, 8'h33, 13'd8);
    send_word(CMD_FREE, 8'h00, 13'd0);
    send_word(CMD_FREE, 8'h5A, 13'd0);
    send_word(CMD_FREE, 8'h5A, 13'd0);

    // Random traffic; run a long stretch back to back in the middle.
    for (int n = 0; n < RAND_WORDS; n++) begin
      no_gaps = (n >= 200 && n < 300);
      send_random_word();
    end
    start <= 1'b0;

    // Drain, then allow one full free sweep for stray words.
    while (ledger.owed_q.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);

    if (ledger.fails == 0 && ledger.owed_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
